[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion on clk_i, disabled while rst_ni is low
`define PBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pbs assertion failed");

// expression must never be true while out of reset
`define PBS_ASSERT_NEVER(label, expr) \
  `PBS_ASSERT(label, !(expr))

`endif

[hw/rtl/pbs_pkg.sv]
// types and constants of the power button sequencer
package pbs_pkg;

  localparam int CountWidth = 16;
  localparam int ThrWidth   = 16;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [ThrWidth-1:0]   thr_t;

  localparam thr_t ThrReset = thr_t'(3000);

  typedef struct packed {
    logic   prev_pressed;
    logic   on_pending;
    logic   button_armed;
    logic   forced_off;
    logic   reset_held;
    count_t hold_count;
  } pbs_state_t;

  typedef struct packed {
    logic supply_on;
    logic supply_off;
    logic reset_hold;
    logic reset_release;
  } pbs_flags_t;

  localparam pbs_state_t StateReset = '{
    prev_pressed: 1'b0,
    on_pending:   1'b0,
    button_armed: 1'b0,
    forced_off:   1'b0,
    reset_held:   1'b1,
    hold_count:   '0
  };

endpackage

[hw/rtl/pbs_if.sv]
// channel interfaces of the power button sequencer
interface pbs_in_if;
  logic valid;
  logic ready;
  logic off_request;
  logic switch_pressed;
  logic supply_good;
  modport source (output valid, output off_request, output switch_pressed,
                  output supply_good, input ready);
  modport sink (input valid, input off_request, input switch_pressed,
                input supply_good, output ready);
endinterface

interface pbs_out_if;
  logic valid;
  logic ready;
  logic supply_on;
  logic supply_off;
  logic reset_hold;
  logic reset_release;
  modport source (output valid, output supply_on, output supply_off,
                  output reset_hold, output reset_release, input ready);
  modport sink (input valid, input supply_on, input supply_off,
                input reset_hold, input reset_release, output ready);
endinterface

interface pbs_cfg_if;
  logic          valid;
  logic          ready;
  pbs_pkg::thr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/pbs_step.sv]
// next state and action flags for one tick
module pbs_step (
  input  pbs_pkg::pbs_state_t state_i,
  input  pbs_pkg::thr_t       thr_i,
  input  logic                off_request_i,
  input  logic                switch_pressed_i,
  input  logic                supply_good_i,
  output pbs_pkg::pbs_state_t state_o,
  output pbs_pkg::pbs_flags_t flags_o
);
  import pbs_pkg::*;

  localparam int CmpWidth = (CountWidth > ThrWidth) ? CountWidth : ThrWidth;
  typedef logic [CmpWidth-1:0] cmp_t;

  localparam count_t CountMax = {CountWidth{1'b1}};

  pbs_state_t st;
  pbs_flags_t fl;
  logic       rise;

  assign rise = switch_pressed_i & ~state_i.prev_pressed;

  always_comb begin
    st = state_i;
    fl = '0;
    if (off_request_i) begin
      st.on_pending   = 1'b0;
      st.button_armed = 1'b0;
      st.forced_off   = 1'b0;
      st.hold_count   = '0;
      st.reset_held   = 1'b1;
      fl.supply_off   = 1'b1;
      fl.reset_hold   = 1'b1;
    end else begin
      // new press
      if (rise) begin
        st.hold_count = '0;
        st.forced_off = 1'b0;
        if (supply_good_i) begin
          st.button_armed = 1'b1;
        end else begin
          st.on_pending   = 1'b1;
          st.button_armed = 1'b0;
          fl.supply_on    = 1'b1;
        end
        st.reset_held = 1'b1;
        fl.reset_hold = 1'b1;
      end
      // reset release on supply good
      if (st.on_pending && supply_good_i) begin
        st.reset_held    = 1'b0;
        st.on_pending    = 1'b0;
        fl.reset_release = 1'b1;
      end else if (supply_good_i && !st.button_armed && !st.on_pending && st.reset_held) begin
        st.reset_held    = 1'b0;
        fl.reset_release = 1'b1;
      end
      // held press counting toward force off
      if (switch_pressed_i && st.button_armed && !st.forced_off) begin
        if ((cmp_t'(st.hold_count) < cmp_t'(thr_i)) && (st.hold_count != CountMax)) begin
          st.hold_count = st.hold_count + count_t'(1);
        end
        if (cmp_t'(st.hold_count) >= cmp_t'(thr_i)) begin
          fl.supply_off   = 1'b1;
          fl.reset_hold   = 1'b1;
          st.reset_held   = 1'b1;
          st.button_armed = 1'b0;
          st.forced_off   = 1'b1;
        end
      end
      if (!switch_pressed_i) begin
        st.hold_count = '0;
        st.forced_off = 1'b0;
      end
    end
    st.prev_pressed = switch_pressed_i;
  end

  assign state_o = st;
  assign flags_o = fl;

endmodule

[hw/rtl/power_button_sequencer.sv]
// power button sequencer top level: one input beat per tick, one result beat
// latency: a result beat is valid the cycle after its input beat is accepted
// throughput: one beat per cycle unless the output stalls; state update and
//   flag logic feed a single output register; input ready follows output ready
// reset: rst_ni low clears state to no press, nothing armed, io reset held,
//   and the force-off threshold returns to 3000 ticks
module power_button_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbs_in_if.sink     in_i,
  pbs_out_if.source  out_o,
  pbs_cfg_if.sink    cfg_i
);
  import pbs_pkg::*;

  // sequencer state, advanced once per accepted input beat
  pbs_state_t state_q, state_d;
  // force-off threshold register
  thr_t       thr_q;
  // output register: valid flag and the action flags of one beat
  logic       out_valid_q;
  pbs_flags_t flags_q, flags_d;

  logic in_fire;

  // take a new beat when the output register is empty or being drained
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;

  pbs_step u_step (
    .state_i          (state_q),
    .thr_i            (thr_q),
    .off_request_i    (in_i.off_request),
    .switch_pressed_i (in_i.switch_pressed),
    .supply_good_i    (in_i.supply_good),
    .state_o          (state_d),
    .flags_o          (flags_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      thr_q       <= ThrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      flags_q <= flags_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.supply_on     = flags_q.supply_on;
  assign out_o.supply_off    = flags_q.supply_off;
  assign out_o.reset_hold    = flags_q.reset_hold;
  assign out_o.reset_release = flags_q.reset_release;

endmodule

[hw/rtl/pbs_checker.sv]
// port-level checks of the power button sequencer and their bind
`include "assert_macros.svh"

module pbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic off_request_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic supply_on_i,
  input logic supply_off_i,
  input logic reset_hold_i,
  input logic reset_release_i
);

  logic in_fire;
  logic [3:0] flags;

  assign in_fire = in_valid_i & in_ready_i;
  assign flags   = {supply_on_i, supply_off_i, reset_hold_i, reset_release_i};

  // an accepted beat shows up at the output in the next cycle
  `PBS_ASSERT(a_result_follows, in_fire |=> out_valid_i)

  // a shutdown request gives exactly supply off and reset hold
  `PBS_ASSERT(a_off_request_flags, (in_fire && off_request_i) |=> (flags == 4'b0110))

  // turning the supply on always holds io reset
  `PBS_ASSERT(a_on_holds_reset, (out_valid_i && supply_on_i) |-> reset_hold_i)

  // supply on and supply off never come in one beat
  `PBS_ASSERT_NEVER(a_on_off_exclusive, out_valid_i && supply_on_i && supply_off_i)

  // a stalled result beat keeps its flags
  `PBS_ASSERT(a_stall_holds, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(flags)))

endmodule

bind power_button_sequencer pbs_checker u_pbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .off_request_i   (in_i.off_request),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .supply_on_i     (out_o.supply_on),
  .supply_off_i    (out_o.supply_off),
  .reset_hold_i    (out_o.reset_hold),
  .reset_release_i (out_o.reset_release)
);
